// ===== design/bug1_pkg.sv =====
`timescale 1ns / 1ps

package bug1_pkg;

    // Number format and counter width
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 32;
    localparam int UNIT_BITS  = 30;

    // Derived widths
    localparam int DIST_W = COORD_BITS - 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int S_MAX  = (DIFF_W > UNIT_BITS) ? (DIFF_W - UNIT_BITS) : 0;
    localparam int S_W    = $clog2(S_MAX + 2);
    localparam int ROOT_W = UNIT_BITS + 1;
    localparam int SQ_W   = 2 * UNIT_BITS + 2;
    localparam int REM_W  = UNIT_BITS + 4;
    localparam int ITER_W = $clog2(ROOT_W + 1);
    localparam int Q_W    = UNIT_BITS + 2;
    localparam int MB_W   = (DIST_W > UNIT_BITS) ? DIST_W : UNIT_BITS;
    localparam int PROD_W = ROOT_W + MB_W;
    localparam int SC_W   = COORD_BITS + 2;
    localparam int SAT_W  = COORD_BITS + 4;
    localparam int GD_W   = ROOT_W + (1 << S_W);

    // Stream word layout
    localparam int MODE_W      = 2;
    localparam int IN_W        = 6 * COORD_BITS + DIST_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 * COORD_BITS + MODE_W + 1;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_MODE_LSB = 2 * COORD_BITS;
    localparam int OUT_DEG_BIT  = 2 * COORD_BITS + MODE_W;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUMPER     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIT_TOL    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEAVE_TOL  = 2'd3;

    localparam logic [DIST_W-1:0] BUMPER_RST =
        DIST_W'(((64'd8 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [DIST_W-1:0] STEP_RST =
        DIST_W'(((64'd6 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [DIST_W-1:0] HIT_TOL_RST =
        DIST_W'(((64'd8 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [DIST_W-1:0] LEAVE_TOL_RST =
        DIST_W'(((64'd45 << FRAC_BITS) + 64'd500) / 64'd1000);

    // Navigation modes
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AWAY     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOWARD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LEAVE    = 2'd3;

    // Scaled products, in issue order
    localparam int SC_IDX_W = 3;
    localparam logic [SC_IDX_W-1:0] SC_AX   = 3'd0;
    localparam logic [SC_IDX_W-1:0] SC_AY   = 3'd1;
    localparam logic [SC_IDX_W-1:0] SC_CX   = 3'd2;
    localparam logic [SC_IDX_W-1:0] SC_CY   = 3'd3;
    localparam logic [SC_IDX_W-1:0] SC_GX   = 3'd4;
    localparam logic [SC_IDX_W-1:0] SC_GY   = 3'd5;
    localparam logic [SC_IDX_W-1:0] SC_LAST = SC_GY;

    // Shared unit operations
    localparam logic UNIT_SQRT = 1'b0;
    localparam logic UNIT_DIV  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic                load_in;
        logic                prep;
        logic                vsel;
        logic                sq_a;
        logic                sq_b;
        logic                start_root;
        logic                cap_root;
        logic                start_div;
        logic                div_y;
        logic                cap_div;
        logic                scale_mul;
        logic                scale_cap;
        logic [SC_IDX_W-1:0] scale_idx;
        logic                commit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic unit_done;
        logic vec_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/bug1_seq_unit.sv =====
`timescale 1ns / 1ps

module bug1_seq_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         op,
    input  logic [bug1_pkg::SQ_W-1:0]    sq_in,
    input  logic [bug1_pkg::UNIT_BITS-1:0] div_num,
    input  logic [bug1_pkg::ROOT_W-1:0]  div_den,
    output logic                         done,
    output logic [bug1_pkg::ROOT_W-1:0]  result
);
    import bug1_pkg::*;

    logic [SQ_W-1:0]   n_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] res_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              op_reg;

    logic [REM_W-1:0]  rem2;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // One result bit per step: root digit or quotient digit
    always_comb
    begin
        if (op_reg == UNIT_SQRT)
        begin
            rem2  = {rem_reg[REM_W-3:0], n_reg[SQ_W-1 -: 2]};
            trial = REM_W'({res_reg, 2'b01});
        end
        else
        begin
            rem2  = {rem_reg[REM_W-2:0], n_reg[SQ_W-1]};
            trial = REM_W'(den_reg);
        end
        ge = (rem2 >= trial);
    end

    // Control: run ROOT_W steps, then pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= op;
            den_reg <= div_den;
            res_reg <= '0;
            if (op == UNIT_SQRT)
            begin
                n_reg   <= sq_in;
                rem_reg <= '0;
            end
            else
            begin
                n_reg   <= {div_num[0], {(SQ_W-1){1'b0}}};
                rem_reg <= REM_W'(div_num >> 1);
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem2 - trial) : rem2;
            res_reg <= {res_reg[ROOT_W-2:0], ge};
            if (op_reg == UNIT_SQRT)
                n_reg <= {n_reg[SQ_W-3:0], 2'b00};
            else
                n_reg <= {n_reg[SQ_W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== design/bug1_dpath.sv =====
`timescale 1ns / 1ps

module bug1_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bug1_pkg::dp_cmd_t                  cmd,
    output bug1_pkg::dp_status_t               status,
    input  logic [bug1_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bug1_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [bug1_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bug1_pkg::DIST_W-1:0]        cfg_data
);
    import bug1_pkg::*;

    localparam int C = COORD_BITS;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [C-1:0] sat_c(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-C:0] top;
        logic [C-1:0]     r;
        top = v[SAT_W-1:C-1];
        if (top == '0 || top == '1)
            r = v[C-1:0];
        else if (v[SAT_W-1])
            r = {1'b1, {(C-1){1'b0}}};
        else
            r = {1'b0, {(C-1){1'b1}}};
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c,
                                                      input logic [COUNT_BITS-1:0] by);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, c} + {1'b0, by};
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    function automatic logic in_box(input logic signed [C-1:0] x, input logic signed [C-1:0] y,
                                    input logic signed [C-1:0] cx,
                                    input logic signed [C-1:0] cy,
                                    input logic [DIST_W-1:0] t);
        logic signed [C+1:0] xe, ye, xl, xh, yl, yh;
        xe = {{2{x[C-1]}}, x};
        ye = {{2{y[C-1]}}, y};
        xl = $signed({{2{cx[C-1]}}, cx}) - $signed({3'b000, t});
        xh = $signed({{2{cx[C-1]}}, cx}) + $signed({3'b000, t});
        yl = $signed({{2{cy[C-1]}}, cy}) - $signed({3'b000, t});
        yh = $signed({{2{cy[C-1]}}, cy}) + $signed({3'b000, t});
        return (xe >= xl) && (xe <= xh) && (ye >= yl) && (ye <= yh);
    endfunction

    function automatic logic signed [SAT_W-1:0] sx(input logic signed [SC_W-1:0] v);
        return {{(SAT_W-SC_W){v[SC_W-1]}}, v};
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] bumper_reg, step_reg, hit_tol_reg, leave_tol_reg;

    logic signed [C-1:0] rx_reg, ry_reg, gx_reg, gy_reg, nx_reg, ny_reg;
    logic [DIST_W-1:0]   nd_reg;

    logic [UNIT_BITS-1:0] ar_reg, br_reg;
    logic                 sa_reg, sb_reg, vz_reg;
    logic [S_W-1:0]       s_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]   acc_reg;
    logic [ROOT_W-1:0] m_reg;
    logic [DIST_W-1:0] gd_reg;
    logic              sneg_reg;

    logic signed [Q_W-1:0] ox_reg, oy_reg, ux_reg, uy_reg;
    logic                  oz_reg, gz_reg;

    logic signed [SC_W-1:0] ax_reg, ay_reg, cx_reg, cy_reg, mgx_reg, mgy_reg;

    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic signed [C-1:0]   hit_px_reg, hit_py_reg, leave_px_reg, leave_py_reg;
    logic signed [C-1:0]   hit_px_next, hit_py_next, leave_px_next, leave_py_next;
    logic [DIST_W-1:0]     best_reg, best_next, ref_reg, ref_next;
    logic [COUNT_BITS-1:0] steps_reg, steps_next, path_reg, path_next;
    logic                  turn_reg, turn_next;

    logic                  out_valid_reg;
    logic [C-1:0]          odx_reg, ody_reg, odx_next, ody_next;
    logic [MODE_W-1:0]     omode_reg;
    logic                  odeg_reg, odeg_next;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bumper_reg    <= BUMPER_RST;
            step_reg      <= STEP_RST;
            hit_tol_reg   <= HIT_TOL_RST;
            leave_tol_reg <= LEAVE_TOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BUMPER:    bumper_reg    <= cfg_data;
                CFG_STEP:      step_reg      <= cfg_data;
                CFG_HIT_TOL:   hit_tol_reg   <= cfg_data;
                CFG_LEAVE_TOL: leave_tol_reg <= cfg_data;
                default:       bumper_reg    <= bumper_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input word capture
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rx_reg <= s_tdata[0*C +: C];
            ry_reg <= s_tdata[1*C +: C];
            gx_reg <= s_tdata[2*C +: C];
            gy_reg <= s_tdata[3*C +: C];
            nx_reg <= s_tdata[4*C +: C];
            ny_reg <= s_tdata[5*C +: C];
            nd_reg <= s_tdata[6*C +: DIST_W];
        end
    end

    // ------------------------------------------------------------------
    // Vector prep: difference, magnitude, reduction shift
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] va, vb;
    logic [DIFF_W-1:0]        ua, ub, uor;
    logic [S_W-1:0]           s_cur;

    always_comb
    begin
        if (cmd.vsel)
        begin
            va = $signed({gx_reg[C-1], gx_reg}) - $signed({rx_reg[C-1], rx_reg});
            vb = $signed({gy_reg[C-1], gy_reg}) - $signed({ry_reg[C-1], ry_reg});
        end
        else
        begin
            va = $signed({nx_reg[C-1], nx_reg}) - $signed({rx_reg[C-1], rx_reg});
            vb = $signed({ny_reg[C-1], ny_reg}) - $signed({ry_reg[C-1], ry_reg});
        end
        ua  = va[DIFF_W-1] ? DIFF_W'(-va) : DIFF_W'(va);
        ub  = vb[DIFF_W-1] ? DIFF_W'(-vb) : DIFF_W'(vb);
        uor = ua | ub;
        s_cur = '0;
        for (int i = 0; i < DIFF_W; i++)
        begin
            if (uor[i] && i >= UNIT_BITS)
                s_cur = S_W'(i - UNIT_BITS + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            ar_reg <= UNIT_BITS'(ua >> s_cur);
            br_reg <= UNIT_BITS'(ub >> s_cur);
            sa_reg <= va[DIFF_W-1];
            sb_reg <= vb[DIFF_W-1];
            vz_reg <= (uor == '0);
            s_reg  <= s_cur;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: squares and scaling
    // ------------------------------------------------------------------
    logic signed [C-1:0]   diff;
    logic signed [Q_W-1:0] sq_q;
    logic signed [C-1:0]   sq_len;
    logic                  sq_neg_extra;
    logic [ROOT_W-1:0]     mul_a;
    logic [MB_W-1:0]       mul_b;
    logic                  sc_neg;

    assign diff = $signed({1'b0, nd_reg}) - $signed({1'b0, ref_reg});

    always_comb
    begin
        sq_neg_extra = 1'b0;
        case (cmd.scale_idx)
            SC_AX:
            begin
                sq_q = oy_reg; sq_len = $signed({1'b0, step_reg}); sq_neg_extra = 1'b1;
            end
            SC_AY:   begin sq_q = ox_reg; sq_len = $signed({1'b0, step_reg}); end
            SC_CX:   begin sq_q = ox_reg; sq_len = diff; end
            SC_CY:   begin sq_q = oy_reg; sq_len = diff; end
            SC_GX:   begin sq_q = ux_reg; sq_len = $signed({1'b0, step_reg}); end
            default: begin sq_q = uy_reg; sq_len = $signed({1'b0, step_reg}); end
        endcase
        sc_neg = sq_q[Q_W-1] ^ sq_len[C-1] ^ sq_neg_extra;

        if (cmd.sq_a)
        begin
            mul_a = ROOT_W'(ar_reg);
            mul_b = MB_W'(ar_reg);
        end
        else if (cmd.sq_b)
        begin
            mul_a = ROOT_W'(br_reg);
            mul_b = MB_W'(br_reg);
        end
        else
        begin
            mul_a = sq_q[Q_W-1] ? ROOT_W'(-sq_q) : ROOT_W'(sq_q);
            mul_b = sq_len[C-1] ? MB_W'(-sq_len) : MB_W'(sq_len);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_a || cmd.sq_b || cmd.scale_mul)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.sq_b)
            acc_reg <= SQ_W'(prod_reg);
        if (cmd.scale_mul)
            sneg_reg <= sc_neg;
    end

    // ------------------------------------------------------------------
    // Root and division unit
    // ------------------------------------------------------------------
    logic              unit_done;
    logic [ROOT_W-1:0] unit_res;

    bug1_seq_unit u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start_root || cmd.start_div),
        .op      (cmd.start_div ? UNIT_DIV : UNIT_SQRT),
        .sq_in   (acc_reg + SQ_W'(prod_reg)),
        .div_num (cmd.div_y ? br_reg : ar_reg),
        .div_den (m_reg),
        .done    (unit_done),
        .result  (unit_res)
    );

    // Goal distance: root shifted back, clipped to largest coordinate
    logic [GD_W-1:0] gd_wide;
    assign gd_wide = GD_W'(unit_res) << s_reg;

    // Signed unit component from the quotient
    logic signed [Q_W-1:0] q_signed;
    assign q_signed = (cmd.div_y ? sb_reg : sa_reg) ? -$signed(Q_W'(unit_res))
                                                     : $signed(Q_W'(unit_res));

    always_ff @(posedge clk)
    begin
        if (cmd.cap_root)
        begin
            m_reg <= unit_res;
            if (cmd.vsel)
            begin
                gz_reg <= vz_reg;
                gd_reg <= (gd_wide > GD_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                              : DIST_W'(gd_wide);
                if (vz_reg)
                begin
                    ux_reg <= '0;
                    uy_reg <= '0;
                end
            end
            else
            begin
                oz_reg <= vz_reg;
                if (vz_reg)
                begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                end
            end
        end
        if (cmd.cap_div)
        begin
            case ({cmd.vsel, cmd.div_y})
                2'b00:   ox_reg <= q_signed;
                2'b01:   oy_reg <= q_signed;
                2'b10:   ux_reg <= q_signed;
                default: uy_reg <= q_signed;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scaled move components
    // ------------------------------------------------------------------
    logic [SC_W-1:0]        sc_mag;
    logic signed [SC_W-1:0] sc_val;

    assign sc_mag = SC_W'(prod_reg >> UNIT_BITS);
    assign sc_val = sneg_reg ? -$signed(sc_mag) : $signed(sc_mag);

    always_ff @(posedge clk)
    begin
        if (cmd.scale_cap)
        begin
            case (cmd.scale_idx)
                SC_AX:   ax_reg  <= sc_val;
                SC_AY:   ay_reg  <= sc_val;
                SC_CX:   cx_reg  <= sc_val;
                SC_CY:   cy_reg  <= sc_val;
                SC_GX:   mgx_reg <= sc_val;
                default: mgy_reg <= sc_val;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Mode update and move selection
    // ------------------------------------------------------------------
    logic                  in_hit, in_leave;
    logic [COUNT_BITS-1:0] steps_mid, path_mid;
    logic signed [SC_W-1:0] tax, tay;

    always_comb
    begin
        mode_next     = mode_reg;
        hit_px_next   = hit_px_reg;
        hit_py_next   = hit_py_reg;
        leave_px_next = leave_px_reg;
        leave_py_next = leave_py_reg;
        best_next     = best_reg;
        ref_next      = ref_reg;
        steps_next    = steps_reg;
        path_next     = path_reg;
        turn_next     = turn_reg;
        odx_next      = '0;
        ody_next      = '0;
        odeg_next     = 1'b0;
        steps_mid     = steps_reg;
        path_mid      = path_reg;
        tax           = turn_reg ? -ax_reg : ax_reg;
        tay           = turn_reg ? -ay_reg : ay_reg;
        in_hit   = in_box(rx_reg, ry_reg, hit_px_reg, hit_py_reg, hit_tol_reg);
        in_leave = in_box(rx_reg, ry_reg, leave_px_reg, leave_py_reg, leave_tol_reg);

        if (mode_reg == MODE_STRAIGHT && nd_reg < bumper_reg)
        begin
            // Contact: store hit point, start circling
            mode_next     = MODE_AWAY;
            hit_px_next   = rx_reg;
            hit_py_next   = ry_reg;
            leave_px_next = rx_reg;
            leave_py_next = ry_reg;
            best_next     = gd_reg;
            steps_next    = cnt_inc(steps_reg, COUNT_BITS'(1));
            ref_next      = nd_reg;
            odx_next      = sat_c(sx(ax_reg) <<< 1);
            ody_next      = sat_c(sx(ay_reg) <<< 1);
            odeg_next     = oz_reg;
        end
        else if (mode_reg == MODE_AWAY)
        begin
            // Track the closest point, then test for return to hit
            if (gd_reg < best_reg)
            begin
                best_next     = gd_reg;
                path_mid      = cnt_inc(path_reg, steps_reg);
                steps_mid     = '0;
                leave_px_next = rx_reg;
                leave_py_next = ry_reg;
            end
            path_next  = path_mid;
            steps_next = steps_mid;
            if (in_hit)
            begin
                mode_next = MODE_TOWARD;
                if (path_mid > steps_mid)
                    turn_next = 1'b1;
            end
            else
            begin
                odx_next   = sat_c(sx(ax_reg) + sx(cx_reg));
                ody_next   = sat_c(sx(ay_reg) + sx(cy_reg));
                steps_next = cnt_inc(steps_mid, COUNT_BITS'(1));
                odeg_next  = oz_reg;
            end
        end
        else if (mode_reg == MODE_TOWARD)
        begin
            // Circle toward the leave point on the chosen side
            if (in_leave)
                mode_next = MODE_LEAVE;
            odx_next  = sat_c(sx(tax) + sx(cx_reg));
            ody_next  = sat_c(sx(tay) + sx(cy_reg));
            odeg_next = oz_reg;
        end
        else
        begin
            // Straight to goal; leaving clears the obstacle bookkeeping
            if (mode_reg == MODE_LEAVE)
            begin
                mode_next     = MODE_STRAIGHT;
                hit_px_next   = {1'b0, {(C-1){1'b1}}};
                hit_py_next   = {1'b0, {(C-1){1'b1}}};
                leave_px_next = '0;
                leave_py_next = '0;
                turn_next     = 1'b0;
                path_next     = '0;
                steps_next    = '0;
            end
            odx_next  = sat_c(sx(mgx_reg));
            ody_next  = sat_c(sx(mgy_reg));
            odeg_next = gz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STRAIGHT;
            hit_px_reg   <= {1'b0, {(C-1){1'b1}}};
            hit_py_reg   <= {1'b0, {(C-1){1'b1}}};
            leave_px_reg <= '0;
            leave_py_reg <= '0;
            best_reg     <= '0;
            ref_reg      <= '0;
            steps_reg    <= '0;
            path_reg     <= '0;
            turn_reg     <= 1'b0;
        end
        else if (cmd.commit)
        begin
            mode_reg     <= mode_next;
            hit_px_reg   <= hit_px_next;
            hit_py_reg   <= hit_py_next;
            leave_px_reg <= leave_px_next;
            leave_py_reg <= leave_py_next;
            best_reg     <= best_next;
            ref_reg      <= ref_next;
            steps_reg    <= steps_next;
            path_reg     <= path_next;
            turn_reg     <= turn_next;
        end
    end

    // ------------------------------------------------------------------
    // Output word register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            odx_reg   <= odx_next;
            ody_reg   <= ody_next;
            omode_reg <= mode_next;
            odeg_reg  <= odeg_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({odeg_reg, omode_reg, ody_reg, odx_reg});

    assign status.unit_done = unit_done;
    assign status.vec_zero  = vz_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

endmodule

// ===== design/bug1_ctrl.sv =====
`timescale 1ns / 1ps

module bug1_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bug1_pkg::dp_status_t  status,
    output bug1_pkg::dp_cmd_t     cmd
);
    import bug1_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] ST_PREP      = 4'd1;
    localparam logic [ST_W-1:0] ST_SQA       = 4'd2;
    localparam logic [ST_W-1:0] ST_SQB       = 4'd3;
    localparam logic [ST_W-1:0] ST_ROOT_GO   = 4'd4;
    localparam logic [ST_W-1:0] ST_ROOT_WAIT = 4'd5;
    localparam logic [ST_W-1:0] ST_DIV_GO    = 4'd6;
    localparam logic [ST_W-1:0] ST_DIV_WAIT  = 4'd7;
    localparam logic [ST_W-1:0] ST_SC_MUL    = 4'd8;
    localparam logic [ST_W-1:0] ST_SC_CAP    = 4'd9;
    localparam logic [ST_W-1:0] ST_COMMIT    = 4'd10;

    logic [ST_W-1:0]     state_reg, state_next;
    logic                vsel_reg, vsel_next;
    logic                divy_reg, divy_next;
    logic [SC_IDX_W-1:0] idx_reg, idx_next;

    // Sequence: obstacle vector, goal vector, six scalings, commit
    always_comb
    begin
        state_next = state_reg;
        vsel_next  = vsel_reg;
        divy_next  = divy_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.vsel      = vsel_reg;
        cmd.div_y     = divy_reg;
        cmd.scale_idx = idx_reg;
        s_tready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    vsel_next   = 1'b0;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SQA;
            end
            ST_SQA:
            begin
                cmd.sq_a   = 1'b1;
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                cmd.sq_b   = 1'b1;
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                cmd.start_root = 1'b1;
                state_next     = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (status.unit_done)
                begin
                    cmd.cap_root = 1'b1;
                    divy_next    = 1'b0;
                    if (!status.vec_zero)
                        state_next = ST_DIV_GO;
                    else if (!vsel_reg)
                    begin
                        vsel_next  = 1'b1;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        idx_next   = SC_AX;
                        state_next = ST_SC_MUL;
                    end
                end
            end
            ST_DIV_GO:
            begin
                cmd.start_div = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.unit_done)
                begin
                    cmd.cap_div = 1'b1;
                    if (!divy_reg)
                    begin
                        divy_next  = 1'b1;
                        state_next = ST_DIV_GO;
                    end
                    else if (!vsel_reg)
                    begin
                        vsel_next  = 1'b1;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        idx_next   = SC_AX;
                        state_next = ST_SC_MUL;
                    end
                end
            end
            ST_SC_MUL:
            begin
                cmd.scale_mul = 1'b1;
                state_next    = ST_SC_CAP;
            end
            ST_SC_CAP:
            begin
                cmd.scale_cap = 1'b1;
                if (idx_reg == SC_LAST)
                    state_next = ST_COMMIT;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SC_MUL;
                end
            end
            ST_COMMIT:
            begin
                // Hold until the output register is free
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vsel_reg  <= 1'b0;
            divy_reg  <= 1'b0;
            idx_reg   <= SC_AX;
        end
        else
        begin
            state_reg <= state_next;
            vsel_reg  <= vsel_next;
            divy_reg  <= divy_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== design/bug1_obstacle_navigator_core.sv =====
`timescale 1ns / 1ps

// Bug1 obstacle navigator: each input word (robot, goal and nearest obstacle
// point, Q16.16) yields one output word with the commanded step, the mode
// after the step and a flag for a zero-length direction vector. One word is
// worked on at a time. The obstacle and goal vectors each need one square root
// and two divisions. All six go one bit per cycle through a single shared
// root/divide unit, at 31 steps each. A zero-length vector skips its two
// divisions. Six scalings then share one multiplier.
// The next input word is accepted while a finished result waits on the output.
// Configuration writes are taken at any edge but belong between words.
module bug1_obstacle_navigator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // robot_x, robot_y, goal_x, goal_y, near_x, near_y, near_dist, zero pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bug1_pkg::IN_TDATA_W-1:0]   s_tdata,
    // move_dx, move_dy, mode_now, degenerate, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bug1_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [bug1_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bug1_pkg::DIST_W-1:0]       cfg_data
);
    import bug1_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bug1_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bug1_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

endmodule

// ===== design/bug1_checker.sv =====
`timescale 1ns / 1ps

module bug1_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [bug1_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bug1_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              cfg_we,
    input logic [bug1_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input logic [bug1_pkg::DIST_W-1:0]       cfg_data
);
    import bug1_pkg::*;

    // Stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // Stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // One word in flight: no acceptance right after an acceptance
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in work");

    // A zero-length direction gives a zero move
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_DEG_BIT] |-> m_tdata[OUT_MODE_LSB-1:0] == '0)
        else $error("degenerate word with nonzero move");

endmodule

bind bug1_obstacle_navigator_core bug1_checker u_bug1_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bug1_pkg::*;

    localparam longint CMAX  = 64'sd2147483647;
    localparam longint CMIN  = -64'sd2147483648;
    localparam longint DMAX  = 64'sd2147483647;
    localparam longint CNTMX = 64'sd4294967295;
    localparam longint ONE   = 64'sd65536;
    localparam longint UNIT  = 64'sd1 << UNIT_BITS;
    localparam int     CYCLE_LIMIT = 3000000;

    typedef struct {
        longint rx, ry, gx, gy, nx, ny, nd;
    } nav_in_t;

    typedef struct {
        logic [31:0] dx, dy;
        logic [1:0]  mode;
        logic        deg;
    } nav_out_t;

    typedef struct {
        longint x, y;
        bit     zero;
    } dir_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [DIST_W-1:0]      cfg_data;

    // navigator state mirror
    logic [1:0] nav_mode;
    longint hit_x, hit_y, leave_x, leave_y, best_dist, ref_dist;
    longint steps_cnt, path_cnt;
    bit     turn_right;
    longint bumper, step_len, hit_tol, leave_tol;

    // stimulus walk
    longint pos_x, pos_y, goal_x, goal_y;

    nav_out_t move_q[$];
    int  err_cnt = 0;
    int  burst_left = 0;
    int  cycles = 0;
    bit  hold_req = 0;

    bug1_obstacle_navigator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint iabs(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint sat_c(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint isqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // Shift both magnitudes below 2^30, return the shift
    function automatic int shrink(inout longint ua, inout longint ub);
        int s;
        s = 0;
        while ((ua >>> s) >= UNIT || (ub >>> s) >= UNIT) s++;
        ua = ua >>> s;
        ub = ub >>> s;
        return s;
    endfunction

    function automatic dir_t unit_dir(longint a, longint b);
        dir_t d;
        longint ua, ub, m;
        int s;
        d.x = 0;
        d.y = 0;
        d.zero = 1;
        ua = iabs(a);
        ub = iabs(b);
        if (ua == 0 && ub == 0) return d;
        s = shrink(ua, ub);
        m = isqrt(ua * ua + ub * ub);
        d.zero = 0;
        d.x = (ua << UNIT_BITS) / m;
        d.y = (ub << UNIT_BITS) / m;
        if (a < 0) d.x = -d.x;
        if (b < 0) d.y = -d.y;
        return d;
    endfunction

    function automatic longint scale_len(longint q, longint len);
        longint uq, ul, r;
        uq = iabs(q);
        ul = iabs(len);
        r = (ul >>> UNIT_BITS) * uq + (((ul & (UNIT - 1)) * uq) >>> UNIT_BITS);
        return ((q < 0) != (len < 0)) ? -r : r;
    endfunction

    function automatic longint goal_dist(longint a, longint b);
        longint ua, ub, r;
        int s;
        ua = iabs(a);
        ub = iabs(b);
        s = shrink(ua, ub);
        r = isqrt(ua * ua + ub * ub);
        if (s > 0 && r > (CMAX >>> s)) return CMAX;
        r = r << s;
        return (r > CMAX) ? CMAX : r;
    endfunction

    function automatic longint cnt_add(longint c, longint by);
        return (CNTMX - c < by) ? CNTMX : c + by;
    endfunction

    function automatic bit in_box(longint x, longint y, longint cx, longint cy, longint t);
        return x >= cx - t && x <= cx + t && y >= cy - t && y <= cy + t;
    endfunction

    function automatic void nav_reset();
        nav_mode   = MODE_STRAIGHT;
        hit_x      = CMAX;
        hit_y      = CMAX;
        leave_x    = 0;
        leave_y    = 0;
        best_dist  = 0;
        ref_dist   = 0;
        steps_cnt  = 0;
        path_cnt   = 0;
        turn_right = 0;
        bumper     = longint'(BUMPER_RST);
        step_len   = longint'(STEP_RST);
        hit_tol    = longint'(HIT_TOL_RST);
        leave_tol  = longint'(LEAVE_TOL_RST);
    endfunction

    // Compute one motion step and advance the mirrored state
    function automatic nav_out_t next_move(nav_in_t it);
        nav_out_t r;
        dir_t o, g;
        longint ax, ay, diff, cx, cy, gd, dx, dy;
        bit degen;
        dx = 0;
        dy = 0;
        degen = 0;
        o = unit_dir(it.nx - it.rx, it.ny - it.ry);
        g = unit_dir(it.gx - it.rx, it.gy - it.ry);
        ax = -scale_len(o.y, step_len);
        ay = scale_len(o.x, step_len);
        diff = it.nd - ref_dist;
        cx = scale_len(o.x, diff);
        cy = scale_len(o.y, diff);
        if (nav_mode == MODE_STRAIGHT && it.nd < bumper)
        begin
            nav_mode  = MODE_AWAY;
            hit_x     = it.rx;
            hit_y     = it.ry;
            leave_x   = it.rx;
            leave_y   = it.ry;
            best_dist = goal_dist(it.gx - it.rx, it.gy - it.ry);
            steps_cnt = cnt_add(steps_cnt, 1);
            dx = sat_c(ax * 2);
            dy = sat_c(ay * 2);
            ref_dist = it.nd;
            degen = o.zero;
        end
        else if (nav_mode == MODE_AWAY)
        begin
            gd = goal_dist(it.gx - it.rx, it.gy - it.ry);
            if (gd < best_dist)
            begin
                best_dist = gd;
                path_cnt  = cnt_add(path_cnt, steps_cnt);
                steps_cnt = 0;
                leave_x   = it.rx;
                leave_y   = it.ry;
            end
            if (in_box(it.rx, it.ry, hit_x, hit_y, hit_tol))
            begin
                nav_mode = MODE_TOWARD;
                if (path_cnt > steps_cnt) turn_right = 1;
            end
            else
            begin
                dx = sat_c(ax + cx);
                dy = sat_c(ay + cy);
                steps_cnt = cnt_add(steps_cnt, 1);
                degen = o.zero;
            end
        end
        else if (nav_mode == MODE_TOWARD)
        begin
            if (in_box(it.rx, it.ry, leave_x, leave_y, leave_tol)) nav_mode = MODE_LEAVE;
            if (turn_right)
            begin
                ax = -ax;
                ay = -ay;
            end
            dx = sat_c(ax + cx);
            dy = sat_c(ay + cy);
            degen = o.zero;
        end
        else
        begin
            if (nav_mode == MODE_LEAVE)
            begin
                nav_mode   = MODE_STRAIGHT;
                hit_x      = CMAX;
                hit_y      = CMAX;
                leave_x    = 0;
                leave_y    = 0;
                turn_right = 0;
                path_cnt   = 0;
                steps_cnt  = 0;
            end
            dx = scale_len(g.x, step_len);
            dy = scale_len(g.y, step_len);
            degen = g.zero;
        end
        r.dx   = dx[31:0];
        r.dy   = dy[31:0];
        r.mode = nav_mode;
        r.deg  = degen;
        return r;
    endfunction

    function automatic nav_in_t mk(longint rx, longint ry, longint gx, longint gy,
                                   longint nx, longint ny, longint nd);
        nav_in_t it;
        it.rx = rx; it.ry = ry; it.gx = gx; it.gy = gy;
        it.nx = nx; it.ny = ny; it.nd = nd;
        return it;
    endfunction

    function automatic longint rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return longint'($signed($urandom()));
        if (k == 1)
        begin
            case ($urandom_range(0, 4))
                0: return CMIN;
                1: return CMAX;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        return longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    endfunction

    function automatic longint rand_dist();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0) return longint'($urandom() & 32'h7fff_ffff);
        if (k == 1)
        begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return DMAX;
                2: return (bumper > 0) ? bumper - 1 : 0;
                default: return bumper;
            endcase
        end
        return longint'($urandom_range(0, 1 << 18));
    endfunction

    // Offset inside a closed box, edges included
    function automatic longint box_off(longint tol);
        longint lim;
        case ($urandom_range(0, 4))
            0: return tol;
            1: return -tol;
            default:
            begin
                lim = (tol > (1 << 16)) ? (1 << 16) : tol;
                return longint'($urandom_range(0, 32'(lim * 2))) - lim;
            end
        endcase
    endfunction

    function automatic longint wander(longint c);
        return sat_c(c + longint'($urandom_range(0, 1 << 18)) - (1 << 17));
    endfunction

    // Build an item that pushes the navigator through its modes
    function automatic nav_in_t shaped_item();
        nav_in_t it;
        longint nd;
        nd = longint'($urandom_range(0, 1 << 20)) + bumper;
        if (nd > DMAX) nd = DMAX;
        case (nav_mode)
            MODE_STRAIGHT:
            begin
                it.rx = wander(pos_x);
                it.ry = wander(pos_y);
                if ($urandom_range(0, 1) && bumper > 0)
                    nd = longint'($urandom_range(0, 32'(bumper - 1)));
            end
            MODE_AWAY:
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    it.rx = sat_c(hit_x + box_off(hit_tol));
                    it.ry = sat_c(hit_y + box_off(hit_tol));
                end
                else
                begin
                    it.rx = wander(pos_x);
                    it.ry = wander(pos_y);
                end
            end
            MODE_TOWARD:
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    it.rx = sat_c(leave_x + box_off(leave_tol));
                    it.ry = sat_c(leave_y + box_off(leave_tol));
                end
                else
                begin
                    it.rx = wander(pos_x);
                    it.ry = wander(pos_y);
                end
            end
            default:
            begin
                it.rx = wander(pos_x);
                it.ry = wander(pos_y);
            end
        endcase
        if (nav_mode != MODE_STRAIGHT)
        begin
            nd = ref_dist + longint'($urandom_range(0, 1 << 15)) - (1 << 14);
            if (nd < 0) nd = 0;
            if (nd > DMAX) nd = DMAX;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            it.nx = it.rx;
            it.ny = it.ry;
        end
        else
        begin
            it.nx = sat_c(it.rx + longint'($urandom_range(0, 1 << 17)) - (1 << 16));
            it.ny = sat_c(it.ry + longint'($urandom_range(0, 1 << 17)) - (1 << 16));
        end
        if ($urandom_range(0, 29) == 0)
        begin
            it.gx = it.rx;
            it.gy = it.ry;
        end
        else
        begin
            it.gx = goal_x;
            it.gy = goal_y;
        end
        it.nd = nd;
        pos_x = it.rx;
        pos_y = it.ry;
        return it;
    endfunction

    function automatic nav_in_t noise_item();
        return mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_dist());
    endfunction

    // Offer one word in bursts with random gaps, wait for its handshake
    task automatic send_word(nav_in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 250);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        move_q.push_back(next_move(it));
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.nd[30:0], it.ny[31:0], it.nx[31:0], it.gy[31:0],
                     it.gx[31:0], it.ry[31:0], it.rx[31:0]};
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    // Drop valid and let the block finish everything in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (move_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_regs(longint b, longint s, longint h, longint l);
        longint v[4];
        v[0] = b; v[1] = s; v[2] = h; v[3] = l;
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= CFG_ADDR_W'(i);
            cfg_data <= v[i][DIST_W-1:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        bumper = b; step_len = s; hit_tol = h; leave_tol = l;
    endtask

    function automatic longint rand_reg();
        case ($urandom_range(0, 3))
            0: return longint'($urandom() & 32'h7fff_ffff);
            1: return longint'($urandom_range(0, 1 << 20));
            default: return longint'($urandom_range(0, 1 << 17));
        endcase
    endfunction

    // Compare each accepted result word with the oldest prediction
    initial
    begin
        nav_out_t e;
        int pat, phase_left, stall_left, hold_left;
        bit rdy;
        pat = 0; phase_left = 0; stall_left = 0; hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (move_q.size() == 0)
                begin
                    $display("%0t unexpected word exp none act %h", $realtime, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    e = move_q.pop_front();
                    if (m_tdata[31:0] !== e.dx)
                    begin
                        $display("%0t move_dx exp %h act %h", $realtime, e.dx, m_tdata[31:0]);
                        err_cnt++;
                    end
                    if (m_tdata[63:32] !== e.dy)
                    begin
                        $display("%0t move_dy exp %h act %h", $realtime, e.dy, m_tdata[63:32]);
                        err_cnt++;
                    end
                    if (m_tdata[OUT_MODE_LSB +: 2] !== e.mode)
                    begin
                        $display("%0t mode_now exp %h act %h", $realtime, e.mode,
                                 m_tdata[OUT_MODE_LSB +: 2]);
                        err_cnt++;
                    end
                    if (m_tdata[OUT_DEG_BIT] !== e.deg)
                    begin
                        $display("%0t degenerate exp %h act %h", $realtime, e.deg,
                                 m_tdata[OUT_DEG_BIT]);
                        err_cnt++;
                    end
                end
            end
            // pick the next ready value
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = 600;
            end
            if (phase_left == 0)
            begin
                pat = $urandom_range(0, 2);
                phase_left = $urandom_range(100, 800);
            end
            phase_left--;
            if (pat == 0)
                rdy = 1'b1;
            else if (pat == 1)
                rdy = ($urandom_range(0, 99) < 60);
            else if (stall_left > 0)
            begin
                rdy = 1'b0;
                stall_left--;
            end
            else
            begin
                rdy = 1'b1;
                if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(1, 40);
            end
            if (hold_left > 0)
            begin
                rdy = 1'b0;
                hold_left--;
            end
            m_tready <= rdy;
        end
    end

    // Every mode and its transitions, plus saturation at the extremes
    task automatic test_directed();
        longint g;
        g = 10 * ONE;
        send_word(mk(0, 0, g, 5 * ONE, 3 * ONE, 3 * ONE, DMAX));
        send_word(mk(ONE, ONE, ONE, ONE, 2 * ONE, ONE, DMAX));
        send_word(mk(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, DMAX));
        send_word(mk(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, DMAX));
        // hit with a zero-length obstacle vector
        send_word(mk(ONE, ONE, g, 5 * ONE, ONE, ONE, 0));
        send_word(mk(ONE + ONE / 2, ONE, g, 5 * ONE, ONE + ONE / 2, 2 * ONE, ONE / 2));
        send_word(mk(2 * ONE, ONE + ONE / 4, g, 5 * ONE, 3 * ONE, ONE, ONE / 3));
        send_word(mk(ONE, 3 * ONE, g, 5 * ONE, 0, 3 * ONE, ONE / 4));
        // back at hit point on the box edge
        send_word(mk(hit_x + hit_tol, hit_y - hit_tol, g, 5 * ONE, 0, 0, ONE / 4));
        send_word(mk(3 * ONE, 2 * ONE, g, 5 * ONE, 3 * ONE, 2 * ONE, ONE / 5));
        send_word(mk(leave_x + leave_tol, leave_y + leave_tol, g, 5 * ONE,
                     4 * ONE, 4 * ONE, ONE / 5));
        // leaving, goal on top of the robot
        send_word(mk(ONE, ONE, ONE, ONE, 0, 0, DMAX));
        send_word(mk(0, 0, g, g, 0, 0, DMAX));
        // doubling and sums saturate with the largest step and bumper
        write_regs(DMAX, DMAX, longint'(HIT_TOL_RST), longint'(LEAVE_TOL_RST));
        send_word(mk(0, 0, g, g, CMAX, CMIN, DMAX - 1));
        send_word(mk(ONE, 0, g, g, CMIN, CMAX, DMAX));
        send_word(mk(2 * ONE, 0, g, g, CMAX, CMAX, 0));
        drain();
    endtask

    task automatic run_items(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                goal_x = rand_coord();
                goal_y = rand_coord();
            end
            if ($urandom_range(0, 4) == 0)
                send_word(noise_item());
            else
                send_word(shaped_item());
        end
    endtask

    task automatic test_config_extremes();
        write_regs(0, 0, 0, 0);
        run_items(60);
        write_regs(DMAX, DMAX, DMAX, DMAX);
        run_items(60);
        write_regs(longint'(BUMPER_RST), longint'(STEP_RST),
                   longint'(HIT_TOL_RST), longint'(LEAVE_TOL_RST));
        run_items(60);
    endtask

    // Stall the output for a long stretch while input keeps coming
    task automatic test_backpressure();
        drain();
        hold_req = 1;
        burst_left = 20;
        run_items(20);
    endtask

    task automatic test_random();
        for (int p = 0; p < 7; p++)
        begin
            write_regs(($urandom_range(0, 2) == 0) ? longint'(BUMPER_RST) : rand_reg(),
                       rand_reg(), rand_reg(), rand_reg());
            run_items(170);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        nav_reset();
        pos_x  = 0;
        pos_y  = 0;
        goal_x = 20 * ONE;
        goal_y = -7 * ONE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        drain();
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
